[hw/rtl/lesf_pkg.sv]
`timescale 1ns / 1ps
package lesf_pkg;

   localparam int CHAR_W  = 8;
   localparam int SIZE_W  = 11;
   localparam int COORD_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 1024;

   localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE    = 2'd2;

   localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET  = 11'd1;
   localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = 11'd1;
   localparam logic [CHAR_W-1:0] OBSTACLE_RESET    = 8'd111;

   // one cell on its way from the scan stage to the update stage
   typedef struct packed {
      logic               valid;
      logic               blocked;
      logic               first_col;
      logic               first_row;
      logic               last;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } stage_type;

endpackage

[hw/rtl/lesf_channels.sv]
`timescale 1ns / 1ps
interface lesf_req_if
   import lesf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cell_char;

   modport source (output valid, output cell_char, input ready);
   modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesf_rsp_if
   import lesf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] origin_x;
   logic [COORD_W-1:0] origin_y;
   logic [SIZE_W-1:0]  square_size;

   modport source (output valid, output origin_x, output origin_y, output square_size,
                   input ready);
   modport sink   (input valid, input origin_x, input origin_y, input square_size,
                   output ready);
endinterface

[hw/rtl/lesf_row_mem.sv]
`timescale 1ns / 1ps
module lesf_row_mem
   import lesf_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [SIZE_W-1:0]      wr_data,
   output logic [SIZE_W-1:0]      rd_data
);

   logic [SIZE_W-1:0] mem [DEPTH];
   logic [SIZE_W-1:0] rd_raw_ff;
   logic [SIZE_W-1:0] byp_data_ff;
   logic              byp_sel_ff;

   // same-cycle write to the entry being read is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff   <= mem[rd_addr];
         byp_sel_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_sel_ff ? byp_data_ff : rd_raw_ff;

endmodule

[hw/rtl/lesf_scan.sv]
`timescale 1ns / 1ps
module lesf_scan
   import lesf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   lesf_req_if.sink              req_bus,
   input  logic                  stall,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   output stage_type             stage_ff,
   output logic [AW-1:0]         stage_addr_ff
);

   logic [SIZE_W-1:0]  grid_width_ff;
   logic [SIZE_W-1:0]  grid_height_ff;
   logic [CHAR_W-1:0]  obstacle_ff;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [SIZE_W-1:0]  width_eff;
   logic [SIZE_W-1:0]  height_eff;
   logic               accept;
   logic               last_col;
   logic               last_row;
   logic [AW-1:0]      addr_in;
   stage_type          stage_in;

   assign req_bus.ready = !stall;
   assign accept        = req_bus.valid && !stall;

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      if (grid_width_ff == '0) begin
         width_eff = SIZE_W'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         width_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         width_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         height_eff = SIZE_W'(1);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         height_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         height_eff = grid_height_ff;
      end
   end

   assign last_col = {1'b0, col_ff} >= (width_eff - SIZE_W'(1));
   assign last_row = {1'b0, row_ff} >= (height_eff - SIZE_W'(1));
   assign addr_in  = (32'(col_ff) < MAX_WIDTH) ? AW'(col_ff) : AW'(MAX_WIDTH - 1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + COORD_W'(1);
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + COORD_W'(1);
         end
      end
      stage_in.valid     = accept;
      stage_in.blocked   = (req_bus.cell_char == obstacle_ff) ||
                           (req_bus.cell_char == NEWLINE_BYTE);
      stage_in.first_col = (col_ff == '0);
      stage_in.first_row = (row_ff == '0);
      stage_in.last      = last_col && last_row;
      stage_in.col       = col_ff;
      stage_in.row       = row_ff;
   end

   assign rd_en   = accept;
   assign rd_addr = addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         obstacle_ff    <= OBSTACLE_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GRID_WIDTH:  grid_width_ff  <= csr_write_data;
               CSR_GRID_HEIGHT: grid_height_ff <= csr_write_data;
               CSR_OBSTACLE:    obstacle_ff    <= csr_write_data[CHAR_W-1:0];
               default: ;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         if (!stall) begin
            stage_ff.valid <= stage_in.valid;
         end
      end
      if (accept) begin
         stage_ff.blocked   <= stage_in.blocked;
         stage_ff.first_col <= stage_in.first_col;
         stage_ff.first_row <= stage_in.first_row;
         stage_ff.last      <= stage_in.last;
         stage_ff.col       <= stage_in.col;
         stage_ff.row       <= stage_in.row;
         stage_addr_ff      <= addr_in;
      end
   end

endmodule

[hw/rtl/lesf_update.sv]
`timescale 1ns / 1ps
module lesf_update
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  stage_type         stage,
   input  logic [SIZE_W-1:0] up_raw,
   output logic              stall,
   output logic              wr_en,
   output logic [SIZE_W-1:0] wr_data,
   lesf_rsp_if.source        rsp_bus
);

   logic [SIZE_W-1:0]  left_ff;
   logic [SIZE_W-1:0]  upper_left_ff;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [COORD_W-1:0] best_x_ff, best_x_in;
   logic [COORD_W-1:0] best_y_ff, best_y_in;
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;
   logic [SIZE_W-1:0]  square_size_ff;
   logic               fire;
   logic [SIZE_W-1:0]  up, left, upper_left, min_lu, min3, size_in;
   logic [SIZE_W-1:0]  x_span, y_span;

   // a finished grid waits only if the result register is still full
   assign stall = stage.valid && stage.last && rsp_valid_ff && !rsp_bus.ready;
   assign fire  = stage.valid && !stall;

   always_comb begin
      up         = stage.first_row ? '0 : up_raw;
      left       = stage.first_col ? '0 : left_ff;
      upper_left = (stage.first_col || stage.first_row) ? '0 : upper_left_ff;
      min_lu     = (up < left) ? up : left;
      min3       = (upper_left < min_lu) ? upper_left : min_lu;
      size_in    = stage.blocked ? '0 : min3 + SIZE_W'(1);
      x_span     = {1'b0, stage.col} + SIZE_W'(1) - size_in;
      y_span     = {1'b0, stage.row} + SIZE_W'(1) - size_in;
      best_size_in = best_size_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      if (size_in > best_size_ff) begin
         best_size_in = size_in;
         best_x_in    = x_span[COORD_W-1:0];
         best_y_in    = y_span[COORD_W-1:0];
      end
   end

   assign wr_en   = fire;
   assign wr_data = size_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
         best_size_ff  <= '0;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            if (stage.last) begin
               left_ff       <= '0;
               upper_left_ff <= '0;
               best_size_ff  <= '0;
               best_x_ff     <= '0;
               best_y_ff     <= '0;
            end else begin
               left_ff       <= size_in;
               upper_left_ff <= up;
               best_size_ff  <= best_size_in;
               best_x_ff     <= best_x_in;
               best_y_ff     <= best_y_in;
            end
         end
         if (fire && stage.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (fire && stage.last) begin
         origin_x_ff    <= best_x_in;
         origin_y_ff    <= best_y_in;
         square_size_ff <= best_size_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.origin_x    = origin_x_ff;
   assign rsp_bus.origin_y    = origin_y_ff;
   assign rsp_bus.square_size = square_size_ff;

endmodule

[hw/rtl/largest_empty_square_finder_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake        payload
// req_bus   in         valid / ready    cell_char (8)
// rsp_bus   out        valid / ready    origin_x (10), origin_y (10), square_size (11)
// csr_*     in         write enable     index (2), data (11)
//
// one cell per cycle sustained unless a stall holds req_bus; each transaction does a
// row buffer read at acceptance and the min-plus-one update and write-back from the
// stage register; the result leaves from an output register loaded by the last update
// synchronous active-high reset; the row buffer is not cleared, the first row
// of every grid treats the cells above it as zero
// req_bus stalls only when a grid ends while the previous result is still held
module largest_empty_square_finder_unit
   import lesf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   lesf_req_if.sink              req_bus,
   lesf_rsp_if.source            rsp_bus
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // scan stage to update stage
   stage_type         stage;
   logic [AW-1:0]     stage_addr;
   logic              stall;

   // row buffer ports
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [SIZE_W-1:0] wr_data;
   logic [SIZE_W-1:0] rd_data;

   // counters, config registers and the read of the cell above
   lesf_scan #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .stall          (stall),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .stage_ff       (stage),
      .stage_addr_ff  (stage_addr)
   );

   // previous row of square sizes, write-back forwarded for one-column grids
   lesf_row_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (stage_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // square size at this corner, best tracking and the result register
   lesf_update u_update (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .up_raw  (rd_data),
      .stall   (stall),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rsp_bus (rsp_bus)
   );

endmodule
